FILE: sv/bilge_factor_table_interpolator_defines.svh
// assertion macros shared by the interpolator rtl
`ifndef BILGE_FACTOR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILGE_FACTOR_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BFTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bfti_pkg.sv
package bfti_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COND_W    = 2;
  localparam int unsigned ACC_W     = DATA_W + 2;
  localparam int unsigned SH_W      = DATA_W + 1;
  localparam int unsigned MUL_STEPS = DATA_W;
  localparam int unsigned DIV_STEPS = DATA_W + 1;
  localparam int unsigned CNT_W     = 6;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  localparam logic [COND_W-1:0] COND_ROUND = 2'd0;
  localparam logic [COND_W-1:0] COND_SHARP = 2'd1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIRST = 8'b0000_0010,
    S_LAST  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_NORM  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

endpackage

FILE: sv/bfti_ram.sv
module bfti_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bilge_factor_table_interpolator.sv
// bilge factor from a breakpoint table: a start transfer with mode low writes one (x, y)
// entry and leaves busy low; with mode high it returns one factor on factor_value_o,
// marked by a single-cycle done_o strobe that cannot be held off, so the receiver must
// take it in that cycle. round and sharp conditions answer from constants, with done_o
// in the cycle after the start transfer. table lookups read entry 0, then the last entry
// in use, then scan spans one entry a cycle through the table ram, which has a separate
// read and write port; a query at or beyond either end returns that end's y. inside the
// table the span found is interpolated by a shift-add multiply and a restoring divide,
// both one bit a cycle on one shared adder. busy is high for the whole table evaluation;
// the table itself has no reset and must be written before it is read
module bilge_factor_table_interpolator
  import bfti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] x_value_i,
  input  logic signed [DATA_W-1:0] y_value_i,
  input  logic [COND_W-1:0]        bilge_condition_i,
  // result strobe
  output logic                     done_o,
  output logic signed [DATA_W-1:0] factor_value_o,
  // entry count register
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  `include "bilge_factor_table_interpolator_defines.svh"

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  // 1.0 and 0.7 in the chosen fixed-point format, 0.7 rounded to nearest
  localparam int unsigned ONE_INT = 1 << FRAC_BITS;
  localparam int unsigned SEVEN_TENTHS_INT = ((7 << FRAC_BITS) + 5) / 10;
  localparam logic [DATA_W-1:0] ONE = DATA_W'(ONE_INT);
  localparam logic [DATA_W-1:0] SEVEN_TENTHS = DATA_W'(SEVEN_TENTHS_INT);

  state_e state_q, state_d;

  logic [CFG_W-1:0]         entries_q;
  logic                     done_q, done_d;
  logic [DATA_W-1:0]        factor_q, factor_d;
  logic signed [DATA_W-1:0] qx_q, qx_d;          // query x
  logic signed [DATA_W-1:0] prev_x_q, prev_x_d;  // left end of the span under test
  logic signed [DATA_W-1:0] prev_y_q, prev_y_d;
  logic signed [DATA_W-1:0] last_y_q, last_y_d;  // fallback for an unsorted table
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic [SH_W-1:0]          mag_q, mag_d;        // |y1 - y0|
  logic                     neg_q, neg_d;        // y1 below y0
  logic [DATA_W-1:0]        w_q, w_d;            // span width
  logic [ACC_W-1:0]         acc_q, acc_d;        // product high part, then remainder
  logic [SH_W-1:0]          sh_q, sh_d;          // product low part, then quotient
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic [ADDR_W-1:0]        last_idx;
  logic [ADDR_W-1:0]        rd_addr;
  logic [2*DATA_W-1:0]      rd_data;
  logic signed [DATA_W-1:0] ram_x, ram_y;
  logic                     wr_en;
  logic                     accept;

  // shared adder / subtractor
  logic [ACC_W-1:0]         au_a, au_b, au_s;
  logic                     au_sub;

  // span test and the differences that follow a hit
  logic                     in_span;
  logic [DATA_W:0]          dy_wide, w_wide, t_wide;
  logic                     div_bit;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign factor_value_o = factor_q;

  // entries in use, held between 2 and the table depth
  always_comb begin
    if (entries_q < CFG_W'(2)) begin
      last_idx = ADDR_W'(1);
    end else if (32'(entries_q) > TABLE_DEPTH) begin
      last_idx = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = ADDR_W'(entries_q - CFG_W'(1));
    end
  end

  // table write happens on the transfer edge; out-of-range indexes are dropped
  assign wr_en = accept && (mode_i == MODE_WRITE) && (32'(entry_index_i) < TABLE_DEPTH);

  bfti_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(entry_index_i)),
    .wdata_i ({x_value_i, y_value_i}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign ram_x = rd_data[2*DATA_W-1:DATA_W];
  assign ram_y = rd_data[DATA_W-1:0];

  // address for the entry needed in the next state
  always_comb begin
    unique case (state_q)
      S_FIRST: rd_addr = last_idx;
      S_LAST:  rd_addr = ADDR_W'(1);
      S_SCAN:  rd_addr = idx_q + ADDR_W'(1);
      default: rd_addr = '0;
    endcase
  end

  assign in_span = (prev_x_q <= qx_q) && (qx_q < ram_x);
  assign dy_wide = {ram_y[DATA_W-1], ram_y} - {prev_y_q[DATA_W-1], prev_y_q};
  assign w_wide  = {ram_x[DATA_W-1], ram_x} - {prev_x_q[DATA_W-1], prev_x_q};
  assign t_wide  = {qx_q[DATA_W-1], qx_q} - {prev_x_q[DATA_W-1], prev_x_q};

  // operand select for the shared unit
  always_comb begin
    au_a   = acc_q;
    au_b   = '0;
    au_sub = 1'b0;
    unique case (state_q)
      S_MUL: begin
        au_b = sh_q[0] ? ACC_W'(mag_q) : '0;
      end
      S_DIV: begin
        au_a   = {acc_q[SH_W-1:0], sh_q[SH_W-1]};
        au_b   = ACC_W'(w_q);
        au_sub = 1'b1;
      end
      S_FIN: begin
        au_a   = {{(ACC_W-DATA_W){prev_y_q[DATA_W-1]}}, prev_y_q};
        au_b   = ACC_W'(sh_q);
        au_sub = neg_q;
      end
      default: begin
        au_a = acc_q;
      end
    endcase
    au_s = au_sub ? (au_a - au_b) : (au_a + au_b);
  end

  assign div_bit = !au_s[ACC_W-1];

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    factor_d = factor_q;
    qx_d     = qx_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    last_y_d = last_y_q;
    idx_d    = idx_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    w_d      = w_q;
    acc_d    = acc_q;
    sh_d     = sh_q;
    cnt_d    = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == MODE_EVAL)) begin
          case (bilge_condition_i)
            COND_ROUND: begin
              factor_d = ONE;
              done_d   = 1'b1;
            end
            COND_SHARP: begin
              factor_d = SEVEN_TENTHS;
              done_d   = 1'b1;
            end
            default: begin
              // other codes go to the table; entry 0 is being read now
              qx_d    = x_value_i;
              state_d = S_FIRST;
            end
          endcase
        end
      end
      S_FIRST: begin
        if (qx_q <= ram_x) begin
          factor_d = ram_y;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          prev_x_d = ram_x;
          prev_y_d = ram_y;
          state_d  = S_LAST;
        end
      end
      S_LAST: begin
        if (qx_q >= ram_x) begin
          factor_d = ram_y;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          last_y_d = ram_y;
          idx_d    = ADDR_W'(1);
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (in_span) begin
          neg_d   = dy_wide[DATA_W];
          mag_d   = dy_wide[DATA_W] ? (SH_W'(0) - dy_wide) : dy_wide;
          w_d     = w_wide[DATA_W-1:0];
          acc_d   = '0;
          sh_d    = {1'b0, t_wide[DATA_W-1:0]};
          cnt_d   = '0;
          state_d = S_MUL;
        end else if (idx_q == last_idx) begin
          // unsorted table with no matching span
          factor_d = last_y_q;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          prev_x_d = ram_x;
          prev_y_d = ram_y;
          idx_d    = idx_q + ADDR_W'(1);
        end
      end
      S_MUL: begin
        // right-shifting shift-add: product ends up as {acc[31:0], sh[31:0]}
        acc_d = ACC_W'(au_s[ACC_W-1:1]);
        sh_d  = {sh_q[SH_W-1], au_s[0], sh_q[DATA_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // quotient fits 33 bits, so the divide starts from product bit 33
        acc_d   = ACC_W'(acc_q[DATA_W-1:1]);
        sh_d    = {acc_q[0], sh_q[DATA_W-1:0]};
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        acc_d = div_bit ? au_s : au_a;
        sh_d  = {sh_q[SH_W-2:0], div_bit};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        factor_d = au_s[DATA_W-1:0];
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      entries_q <= CFG_W'(2);
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    qx_q     <= qx_d;
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    last_y_q <= last_y_d;
    idx_q    <= idx_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    w_q      <= w_d;
    acc_q    <= acc_d;
    sh_q     <= sh_d;
    cnt_q    <= cnt_d;
  end

  `BFTI_ASSERT_NEXT(a_write_no_result, accept && (mode_i == MODE_WRITE), !done_o,
    "table write produced a result")
  `BFTI_ASSERT_NEXT(a_round_is_one,
    accept && (mode_i == MODE_EVAL) && (bilge_condition_i == COND_ROUND),
    done_o && (factor_value_o == ONE), "round bilge did not give 1.0")
  `BFTI_ASSERT_IMP(a_scan_in_range, state_q == S_SCAN, idx_q <= last_idx,
    "span scan ran past the last entry")
  `BFTI_ASSERT_IMP(a_rem_below_div, state_q == S_DIV, acc_q < ACC_W'(w_q),
    "divide remainder not below span width")
  `BFTI_ASSERT_IMP(a_busy_end_done, $fell(busy), done_o,
    "evaluation ended without a result")

endmodule
